/* design/mqorf_pkg.sv */
// Shared types and constants for the multi-queue overwrite ring FIFO.
// No dependencies; used by every module in the design folder.
`default_nettype none

package mqorf_pkg;

	// Default geometry
	localparam int DEPTH_DEF  = 64;
	localparam int QUEUES_DEF = 2;

	// Fixed field widths of the word ports
	localparam int DATA_W   = 8;
	localparam int STATUS_W = 2;
	localparam int LEVEL_W  = 7;

	// Access codes
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_PUSHED = 2'd0,
		ST_POPPED = 2'd1,
		ST_EMPTY  = 2'd2
	} status_t;

	// Slot store command issued by the control unit
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_cmd_t;

endpackage

`default_nettype wire

/* design/mqorf_store.sv */
// Slot store: one synchronous byte memory shared by all queues.
// Depends on mqorf_pkg for the data width and the command struct.
`default_nettype none

module mqorf_store #(
	parameter int DEPTH  = mqorf_pkg::DEPTH_DEF,
	parameter int QUEUES = mqorf_pkg::QUEUES_DEF,
	localparam int AW    = (QUEUES * DEPTH > 2) ? $clog2(QUEUES * DEPTH) : 1
) (
	input  wire logic                        clk,
	input  wire mqorf_pkg::mem_cmd_t         cmd,
	input  wire logic [AW-1:0]               addr,
	input  wire logic [mqorf_pkg::DATA_W-1:0] wdata,
	output logic      [mqorf_pkg::DATA_W-1:0] rdata
);

	logic [mqorf_pkg::DATA_W-1:0] mem_q [QUEUES * DEPTH];
	logic [mqorf_pkg::DATA_W-1:0] rdata_q;

	// Single port: write on push, registered read on pop
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem_q[addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* design/mqorf_ctrl.sv */
// Queue control: per-queue read/write pointers and level counters,
// store address generation and the registered result status/level.
// Depends on mqorf_pkg.
`default_nettype none

module mqorf_ctrl #(
	parameter int DEPTH  = mqorf_pkg::DEPTH_DEF,
	parameter int QUEUES = mqorf_pkg::QUEUES_DEF,
	localparam int AW    = (QUEUES * DEPTH > 2) ? $clog2(QUEUES * DEPTH) : 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic                          action,
	input  wire logic                          queue_index,
	output mqorf_pkg::mem_cmd_t                cmd,
	output logic      [AW-1:0]                 addr,
	output logic                               done_s1,
	output logic      [mqorf_pkg::STATUS_W-1:0] status_s1,
	output logic      [mqorf_pkg::LEVEL_W-1:0]  level_s1
);

	localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
	localparam int LW = $clog2(DEPTH + 1);
	localparam int QW = (QUEUES > 2) ? $clog2(QUEUES) : 1;
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [LW-1:0] LVL_MAX  = LW'(DEPTH);

	logic [PW-1:0] rd_ptr_q [QUEUES];
	logic [PW-1:0] wr_ptr_q [QUEUES];
	logic [LW-1:0] lvl_q    [QUEUES];

	logic [QW-1:0] q;
	logic [PW-1:0] rd, wr, rd_n, wr_n;
	logic [LW-1:0] lvl, lvl_base, lvl_n;
	logic          empty;
	mqorf_pkg::status_t st;
	logic [PW-1:0] ptr_sel;

	function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
		next_slot = (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	// Queue select wraps when there is only one queue
	assign q = (QUEUES > 1) ? QW'(queue_index) : '0;

	assign rd    = rd_ptr_q[q];
	assign wr    = wr_ptr_q[q];
	assign lvl   = lvl_q[q];
	assign empty = (wr == rd);

	// Pointer and level update for the selected queue
	always_comb begin
		rd_n     = rd;
		wr_n     = wr;
		lvl_base = empty ? '0 : lvl;
		lvl_n    = lvl;
		st       = mqorf_pkg::ST_PUSHED;
		ptr_sel  = wr;
		if (action == mqorf_pkg::ACT_PUSH) begin
			// push overwrites the oldest byte when the ring is full
			wr_n  = next_slot(wr);
			rd_n  = (next_slot(wr) == rd) ? next_slot(rd) : rd;
			lvl_n = (lvl_base == LVL_MAX) ? LVL_MAX : lvl_base + LW'(1);
		end else if (empty) begin
			lvl_n = '0;
			st    = mqorf_pkg::ST_EMPTY;
		end else begin
			rd_n    = next_slot(rd);
			lvl_n   = (lvl == '0) ? '0 : lvl - LW'(1);
			st      = mqorf_pkg::ST_POPPED;
			ptr_sel = rd;
		end
	end

	// Store command: write on push, read on a non-empty pop
	assign addr      = AW'(q) * AW'(DEPTH) + AW'(ptr_sel);
	assign cmd.wr_en = accept && (action == mqorf_pkg::ACT_PUSH);
	assign cmd.rd_en = accept && (st == mqorf_pkg::ST_POPPED);

	// Per-queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUES; i++) begin
				rd_ptr_q[i] <= '0;
				wr_ptr_q[i] <= '0;
				lvl_q[i]    <= '0;
			end
		end else if (accept) begin
			rd_ptr_q[q] <= rd_n;
			wr_ptr_q[q] <= wr_n;
			lvl_q[q]    <= lvl_n;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	// Result payload, aligned with the store read data
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= mqorf_pkg::STATUS_W'(st);
			level_s1  <= mqorf_pkg::LEVEL_W'(lvl_n);
		end
	end

endmodule

`default_nettype wire

/* design/multi_queue_overwrite_ring_fifo.sv */
// Top level of the multi-queue overwrite ring FIFO.
// Depends on mqorf_pkg, mqorf_ctrl and mqorf_store.
//
// Usage:
//   Command channel: drive action, queue_index and push_data and raise
//   start; the word is taken at the rising edge where start is high and
//   busy is low. busy stays low: the block takes a word on every cycle.
//   Result channel: done is high in the cycle after the command was
//   taken, with pop_data, status and level valid in that
//   cycle. The receiver cannot stall; results must be captured then.
//   Throughput is one word per cycle. The result timing follows from the
//   slot store: a single-port memory with a registered read, addressed
//   straight from the pointer registers.
//   A push never fails: on a full ring the oldest byte is dropped.
//   Reset (arst_n low) clears all pointers and level counters, so every
//   queue is empty; the slot store itself is not cleared and needs no
//   clearing pass, since a pop only reads slots a push has written.
`default_nettype none

module multi_queue_overwrite_ring_fifo #(
	parameter int DEPTH  = mqorf_pkg::DEPTH_DEF,
	parameter int QUEUES = mqorf_pkg::QUEUES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic                           action,
	input  wire logic                           queue_index,
	input  wire logic [mqorf_pkg::DATA_W-1:0]   push_data,
	output logic                                done,
	output logic      [mqorf_pkg::DATA_W-1:0]   pop_data,
	output logic      [mqorf_pkg::STATUS_W-1:0] status,
	output logic      [mqorf_pkg::LEVEL_W-1:0]  level
);

	localparam int AW = (QUEUES * DEPTH > 2) ? $clog2(QUEUES * DEPTH) : 1;

	logic                         accept;
	mqorf_pkg::mem_cmd_t          cmd;
	logic [AW-1:0]                addr;
	logic [mqorf_pkg::DATA_W-1:0] rdata;

	// One access per cycle; no interlock needed
	assign busy   = 1'b0;
	assign accept = start && !busy;

	mqorf_ctrl #(
		.DEPTH  (DEPTH),
		.QUEUES (QUEUES)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.action      (action),
		.queue_index (queue_index),
		.cmd         (cmd),
		.addr        (addr),
		.done_s1     (done),
		.status_s1   (status),
		.level_s1    (level)
	);

	mqorf_store #(
		.DEPTH  (DEPTH),
		.QUEUES (QUEUES)
	) u_store (
		.clk   (clk),
		.cmd   (cmd),
		.addr  (addr),
		.wdata (push_data),
		.rdata (rdata)
	);

	// Pop data only on a successful pop
	assign pop_data = (status == mqorf_pkg::STATUS_W'(mqorf_pkg::ST_POPPED)) ? rdata : '0;

endmodule

`default_nettype wire

/* dv/multi_queue_overwrite_ring_fifo_test.sv */
// Self-checking testbench for multi_queue_overwrite_ring_fifo: directed and random queue accesses.
// Predicts every result word in-line and compares it field by field as it comes back.
// Depends on mqorf_pkg and the design top level only.
`timescale 1ns / 100ps

module multi_queue_overwrite_ring_fifo_test;
	import mqorf_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int QUEUES     = QUEUES_DEF;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int IDLE_LIMIT = 200;

	typedef struct {
		logic [DATA_W-1:0]  data;
		status_t            status;
		logic [LEVEL_W-1:0] level;
	} result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                action;
	logic                queue_index;
	logic [DATA_W-1:0]   push_data;
	logic                done;
	logic [DATA_W-1:0]   pop_data;
	logic [STATUS_W-1:0] status;
	logic [LEVEL_W-1:0]  level;

	// Shadow copy of the queues
	logic [DATA_W-1:0]  ring_bytes [QUEUES][DEPTH];
	logic [PTR_W-1:0]   head_ptr   [QUEUES];
	logic [PTR_W-1:0]   tail_ptr   [QUEUES];
	logic [LEVEL_W-1:0] fill_level [QUEUES];

	result_t pending_results[$];
	int      err_count;
	int      idle_run;
	bit      gaps_on;
	bit      gaps_locked;
	int      n_push, n_pop, n_empty, n_drop, n_sat;

	multi_queue_overwrite_ring_fifo u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.action      (action),
		.queue_index (queue_index),
		.push_data   (push_data),
		.done        (done),
		.pop_data    (pop_data),
		.status      (status),
		.level       (level)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Apply one access to the shadow queues and return the word it should produce
	function automatic result_t ring_access(input logic act, input logic q,
			input logic [DATA_W-1:0] d);
		result_t r;
		int      qi;
		qi = int'(q) % QUEUES;
		r.data = '0;
		if (act == ACT_PUSH) begin
			if (tail_ptr[qi] == head_ptr[qi])
				fill_level[qi] = '0;
			ring_bytes[qi][tail_ptr[qi]] = d;
			tail_ptr[qi] = bump(tail_ptr[qi]);
			if (tail_ptr[qi] == head_ptr[qi]) begin
				head_ptr[qi] = bump(head_ptr[qi]);
				n_drop++;
			end
			if (fill_level[qi] < LEVEL_W'(DEPTH))
				fill_level[qi] = fill_level[qi] + 1'b1;
			else
				n_sat++;
			r.status = ST_PUSHED;
			n_push++;
		end else if (tail_ptr[qi] == head_ptr[qi]) begin
			fill_level[qi] = '0;
			r.status = ST_EMPTY;
			n_empty++;
		end else begin
			r.data = ring_bytes[qi][head_ptr[qi]];
			head_ptr[qi] = bump(head_ptr[qi]);
			if (fill_level[qi] != '0)
				fill_level[qi] = fill_level[qi] - 1'b1;
			r.status = ST_POPPED;
			n_pop++;
		end
		r.level = fill_level[qi];
		return r;
	endfunction

	// Result check first, then predict the word taken at this edge
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with nothing expected: data %0h status %0d level %0d",
					$realtime, pop_data, status, level);
				err_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (pop_data !== exp_r.data) begin
					$display("%0t: pop_data expected %0h actual %0h",
						$realtime, exp_r.data, pop_data);
					err_count++;
				end
				if (status !== exp_r.status) begin
					$display("%0t: status expected %0d actual %0d",
						$realtime, exp_r.status, status);
					err_count++;
				end
				if (level !== exp_r.level) begin
					$display("%0t: level expected %0d actual %0d",
						$realtime, exp_r.level, level);
					err_count++;
				end
			end
		end
		if (arst_n && start && !busy)
			pending_results.push_back(ring_access(action, queue_index, push_data));
	end

	// Watchdog: nothing taken on either side for too long
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_run <= 0;
		else if (idle_run >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $realtime, IDLE_LIMIT);
			$display("multi_queue_overwrite_ring_fifo_test: errors");
			$finish;
		end else
			idle_run <= idle_run + 1;
	end

	task automatic idle_cycles(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// Send one word and wait until the block takes it
	task automatic send_word(input logic act, input logic q, input logic [DATA_W-1:0] d);
		@(negedge clk);
		start       <= 1'b1;
		action      <= act;
		queue_index <= q;
		push_data   <= d;
		do
			@(posedge clk);
		while (!(start && !busy));
		if (gaps_on && $urandom_range(0, 3) == 0)
			idle_cycles($urandom_range(1, 11));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Empty pops, data extremes, both queues, interleaving
	task automatic test_directed();
		send_word(ACT_POP, 1'b0, 8'h00);
		send_word(ACT_POP, 1'b1, 8'hFF);
		send_word(ACT_PUSH, 1'b0, 8'h00);
		send_word(ACT_PUSH, 1'b0, 8'hFF);
		send_word(ACT_PUSH, 1'b1, 8'hA5);
		send_word(ACT_PUSH, 1'b1, 8'h5A);
		send_word(ACT_POP, 1'b0, 8'h3C);
		send_word(ACT_POP, 1'b1, 8'h00);
		send_word(ACT_POP, 1'b0, 8'hFF);
		send_word(ACT_POP, 1'b0, 8'h00);
		send_word(ACT_POP, 1'b1, 8'h00);
		send_word(ACT_POP, 1'b1, 8'h00);
		send_word(ACT_PUSH, 1'b1, 8'h01);
		send_word(ACT_PUSH, 1'b0, 8'h80);
		send_word(ACT_POP, 1'b1, 8'h00);
		send_word(ACT_POP, 1'b0, 8'h00);
	endtask

	// Overfill a queue so the oldest bytes drop and the level saturates, then
	// drain it and clear the leftover level by an empty pop or by a push
	task automatic test_overwrite(input logic q, input bit clear_by_push);
		repeat (DEPTH + 6)
			send_word(ACT_PUSH, q, DATA_W'($urandom_range(0, 255)));
		repeat (DEPTH - 1)
			send_word(ACT_POP, q, DATA_W'($urandom_range(0, 255)));
		if (clear_by_push) begin
			send_word(ACT_PUSH, q, DATA_W'($urandom_range(0, 255)));
			send_word(ACT_POP, q, 8'h00);
		end
		send_word(ACT_POP, q, 8'h00);
	endtask

	// Random traffic at a given push percentage; the callers push-bias, pop-bias or balance the queues
	task automatic test_random_mix(input int n_words, input int push_pct);
		logic q;
		q = 1'b0;
		for (int i = 0; i < n_words; i++) begin
			// gap pattern changes every 40 words unless it is pinned off
			if (!gaps_locked && i % 40 == 0)
				gaps_on = ($urandom_range(0, 2) != 0);
			if ($urandom_range(0, 3) == 0)
				q = 1'($urandom_range(0, 1));
			send_word(($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP, q,
				DATA_W'($urandom_range(0, 255)));
		end
	endtask

	// Let every result come back before sending more
	task automatic test_drain_pause();
		test_random_mix(30, 60);
		wait_drained();
		test_random_mix(30, 40);
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		action      = ACT_PUSH;
		queue_index = 1'b0;
		push_data   = '0;
		err_count   = 0;
		idle_run    = 0;
		gaps_on     = 1'b1;
		gaps_locked = 1'b0;
		n_push = 0; n_pop = 0; n_empty = 0; n_drop = 0; n_sat = 0;
		for (int q = 0; q < QUEUES; q++) begin
			head_ptr[q]   = '0;
			tail_ptr[q]   = '0;
			fill_level[q] = '0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_overwrite(1'b0, 1'b0);
		test_overwrite(1'b1, 1'b1);
		test_random_mix(250, 75);
		test_random_mix(200, 30);
		test_random_mix(200, 52);
		test_drain_pause();

		// final stretch back to back
		gaps_on     = 1'b0;
		gaps_locked = 1'b1;
		test_random_mix(150, 50);

		wait_drained();
		repeat (3) @(posedge clk);
		$display("covered %0d pushes (%0d dropping the oldest, %0d at saturated level),",
			n_push, n_drop, n_sat);
		$display("%0d pops and %0d empty pops across %0d queues", n_pop, n_empty, QUEUES);
		if (err_count == 0)
			$display("multi_queue_overwrite_ring_fifo_test: clean");
		else
			$display("multi_queue_overwrite_ring_fifo_test: errors");
		$finish;
	end

endmodule
